>>> design/filter_expression_lexer_macros.svh
// Assertion macros used by the fel_back lexer module.
`ifndef FILTER_EXPRESSION_LEXER_MACROS_SVH
`define FILTER_EXPRESSION_LEXER_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define FEL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next.
`define FEL_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> design/fel_pkg.sv
`default_nettype none
package fel_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int BUF_DEPTH = 5;
  localparam int MAX_RECORDS = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_OPER,
    MODE_NUMBER,
    MODE_IDENT
  } lex_mode_t;

  typedef enum logic [1:0] {
    REC_VALUE,
    REC_CLOSED,
    REC_END,
    REC_ERROR
  } rec_kind_t;

  localparam logic [2:0] TOK_COMMA = 3'd0;
  localparam logic [2:0] TOK_PAREN = 3'd1;
  localparam logic [2:0] TOK_STRING = 3'd2;
  localparam logic [2:0] TOK_OPER = 3'd3;
  localparam logic [2:0] TOK_NUMBER = 3'd4;
  localparam logic [2:0] TOK_IDENT = 3'd5;
  localparam logic [2:0] TOK_KEYWORD = 3'd6;

  localparam logic [1:0] ERR_UNCLOSED = 2'd0;
  localparam logic [1:0] ERR_BAD_OPER = 2'd1;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd2;

  typedef logic [BUF_DEPTH-1:0][7:0] word_buf_t;

  typedef struct packed {
    rec_kind_t   rec_kind;
    logic [2:0]  tok_kind;
    logic [7:0]  vchar;
    logic [15:0] pos;
    logic [15:0] len;
    logic [4:0]  widx;
    logic [1:0]  ecode;
  } rec_t;

  typedef struct packed {
    logic [2:0]                   count;
    logic [MAX_RECORDS-1:0][$bits(rec_t)-1:0] recs;
  } bundle_t;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } match_t;

  localparam int NUM_OPS = 19;
  localparam int NUM_KWS = 5;

  localparam logic [23:0] OP_CHARS [NUM_OPS] = '{
    24'h000021, 24'h00002A, 24'h002A2A, 24'h00002F, 24'h00002B,
    24'h00002D, 24'h000025, 24'h000026, 24'h00007C, 24'h00005E,
    24'h00003C, 24'h00003E, 24'h003D3E, 24'h003D3C, 24'h003D3D,
    24'h003D21, 24'h00003D, 24'h3D3D3D, 24'h3D3D21
  };
  localparam logic [1:0] OP_LENS [NUM_OPS] = '{
    2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd3, 2'd3
  };
  localparam logic [39:0] KW_CHARS [NUM_KWS] = '{
    40'h0000006E69, 40'h00656B696C, 40'h0065757274, 40'h65736C6166, 40'h006C6C756E
  };
  localparam logic [2:0] KW_LENS [NUM_KWS] = '{3'd2, 3'd4, 3'd4, 3'd5, 3'd4};

  function automatic match_t find_op(word_buf_t b, logic [15:0] cnt);
    match_t m;
    logic   hit;
    m = '0;
    for (int i = NUM_OPS - 1; i >= 0; i--) begin
      hit = (cnt == 16'(OP_LENS[i]));
      for (int j = 0; j < 3; j++) begin
        if (j < int'(OP_LENS[i]) && b[j] != OP_CHARS[i][8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        m.found = 1'b1;
        m.idx = 5'(i);
      end
    end
    return m;
  endfunction

  function automatic match_t find_kw(word_buf_t b, logic [15:0] cnt);
    match_t m;
    logic   hit;
    m = '0;
    for (int i = NUM_KWS - 1; i >= 0; i--) begin
      hit = (cnt == 16'(KW_LENS[i]));
      for (int j = 0; j < BUF_DEPTH; j++) begin
        if (j < int'(KW_LENS[i]) && b[j] != KW_CHARS[i][8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        m.found = 1'b1;
        m.idx = 5'(i);
      end
    end
    return m;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

endpackage
`default_nettype wire

>>> design/fel_front.sv
`default_nettype none
module fel_front import fel_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       byte_valid,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            push,
  output bundle_t         push_data,
  input  wire logic       queue_full
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  lex_mode_t               mode, mode_next;
  logic                    quote_single, quote_single_next;
  logic                    esc, esc_next;
  word_buf_t               wbuf, wbuf_next;
  logic [15:0]             wcount, wcount_next;
  logic [POSITION_BITS-1:0] tstart, tstart_next;
  logic [POSITION_BITS-1:0] offset, offset_next;
  logic                    err, err_next;

  logic                    accept;
  bundle_t                 bnd;

  function automatic logic [15:0] to16(logic [POSITION_BITS-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[15:0];
  endfunction

  function automatic bundle_t add_rec(bundle_t b, rec_t r);
    bundle_t o;
    o = b;
    if (b.count < 3'(MAX_RECORDS)) begin
      o.recs[b.count[1:0]] = r;
      o.count = b.count + 3'd1;
    end
    return o;
  endfunction

  function automatic rec_t mk(rec_kind_t rk, logic [2:0] tk, logic [7:0] vc,
                              logic [15:0] pos, logic [15:0] len, logic [4:0] wi,
                              logic [1:0] ec);
    rec_t r;
    r.rec_kind = rk;
    r.tok_kind = tk;
    r.vchar = vc;
    r.pos = pos;
    r.len = len;
    r.widx = wi;
    r.ecode = ec;
    return r;
  endfunction

  // Closing record of an operator, number or word run; an operator that is
  // not in the table gives an error record instead.
  function automatic rec_t close_rec(lex_mode_t m, word_buf_t b, logic [15:0] cnt,
                                     logic [15:0] pos);
    match_t om;
    match_t km;
    rec_t   r;
    om = find_op(b, cnt);
    km = find_kw(b, cnt);
    r = mk(REC_CLOSED, TOK_IDENT, 8'd0, pos, cnt, 5'd0, 2'd0);
    if (m == MODE_OPER) begin
      if (om.found) begin
        r.tok_kind = TOK_OPER;
        r.widx = om.idx;
      end else begin
        r = mk(REC_ERROR, 3'd0, 8'd0, pos, 16'd0, 5'd0, ERR_BAD_OPER);
      end
    end else if (m == MODE_NUMBER) begin
      r.tok_kind = TOK_NUMBER;
    end else if (km.found) begin
      r.tok_kind = TOK_KEYWORD;
      r.widx = km.idx;
    end
    return r;
  endfunction

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;
  assign push = accept && (bnd.count != 3'd0);
  assign push_data = bnd;

  always_comb begin
    logic [POSITION_BITS-1:0] at;
    logic [7:0]               c;
    logic [7:0]               d;
    logic                     start;
    logic                     more;
    logic                     appnd;
    logic [2:0]               kind;
    rec_t                     cr;
    mode_next = mode;
    quote_single_next = quote_single;
    esc_next = esc;
    wbuf_next = wbuf;
    wcount_next = wcount;
    tstart_next = tstart;
    offset_next = offset;
    err_next = err;
    bnd = '0;
    at = offset;
    c = text_byte;
    d = text_byte;
    start = 1'b0;
    more = 1'b0;
    appnd = 1'b0;
    kind = TOK_IDENT;
    cr = '0;

    if (byte_valid) begin
      if (offset < POS_MAX) offset_next = offset + 1'b1;
      if (!err) begin
        if (mode == MODE_STRING) begin
          if (esc) begin
            case (c)
              8'h6E: d = 8'd10;
              8'h72: d = 8'd13;
              8'h74: d = 8'd9;
              default: d = c;
            endcase
            esc_next = 1'b0;
            appnd = 1'b1;
          end else if (c == (quote_single ? 8'h27 : 8'h22)) begin
            bnd = add_rec(bnd, mk(REC_CLOSED, TOK_STRING, 8'd0, to16(tstart), wcount,
                                  5'd0, 2'd0));
            mode_next = MODE_IDLE;
          end else if (c == 8'h5C) begin
            esc_next = 1'b1;
          end else begin
            appnd = 1'b1;
          end
          kind = TOK_STRING;
        end else begin
          start = 1'b1;
          if (mode != MODE_IDLE) begin
            case (mode)
              MODE_OPER: begin
                more = is_punct(c);
                kind = TOK_OPER;
              end
              MODE_NUMBER: begin
                more = is_digit(c) || c == 8'h2E;
                kind = TOK_NUMBER;
              end
              default: begin
                more = is_alpha(c) || is_digit(c) || c == 8'h5F;
                kind = TOK_IDENT;
              end
            endcase
            if (more) begin
              appnd = 1'b1;
              start = 1'b0;
            end else begin
              cr = close_rec(mode, wbuf, wcount, to16(tstart));
              bnd = add_rec(bnd, cr);
              mode_next = MODE_IDLE;
              if (cr.rec_kind == REC_ERROR) begin
                err_next = 1'b1;
                start = 1'b0;
              end
            end
          end
          if (start && !is_space(c)) begin
            if (c == 8'h2C || c == 8'h28 || c == 8'h29) begin
              kind = (c == 8'h2C) ? TOK_COMMA : TOK_PAREN;
              bnd = add_rec(bnd, mk(REC_VALUE, kind, c, to16(at), 16'd0, 5'd0, 2'd0));
              bnd = add_rec(bnd, mk(REC_CLOSED, kind, 8'd0, to16(at), 16'd1, 5'd0, 2'd0));
            end else begin
              tstart_next = at;
              wcount_next = 16'd0;
              esc_next = 1'b0;
              if (c == 8'h22 || c == 8'h27) begin
                mode_next = MODE_STRING;
                quote_single_next = (c == 8'h27);
              end else if (is_punct(c) || is_digit(c) || is_alpha(c)) begin
                if (is_punct(c)) begin
                  mode_next = MODE_OPER;
                  kind = TOK_OPER;
                end else if (is_digit(c)) begin
                  mode_next = MODE_NUMBER;
                  kind = TOK_NUMBER;
                end else begin
                  mode_next = MODE_IDENT;
                  kind = TOK_IDENT;
                end
                appnd = 1'b1;
              end else begin
                bnd = add_rec(bnd, mk(REC_ERROR, 3'd0, 8'd0, to16(at), 16'd0, 5'd0,
                                      ERR_BAD_CHAR));
                err_next = 1'b1;
                mode_next = MODE_IDLE;
              end
            end
          end
        end
        if (appnd) begin
          if (wcount_next < 16'(BUF_DEPTH)) wbuf_next[wcount_next[2:0]] = d;
          bnd = add_rec(bnd, mk(REC_VALUE, kind, d, to16(tstart_next), 16'd0, 5'd0,
                                2'd0));
          if (wcount_next != 16'hFFFF) wcount_next = wcount_next + 16'd1;
        end
      end
    end

    if (end_of_text) begin
      if (!err_next) begin
        if (mode_next == MODE_STRING) begin
          bnd = add_rec(bnd, mk(REC_ERROR, 3'd0, 8'd0, to16(tstart_next), 16'd0, 5'd0,
                                ERR_UNCLOSED));
        end else begin
          cr = mk(REC_END, 3'd0, 8'd0, to16(offset_next), 16'd0, 5'd0, 2'd0);
          if (mode_next != MODE_IDLE) begin
            bnd = add_rec(bnd, close_rec(mode_next, wbuf_next, wcount_next,
                                         to16(tstart_next)));
            if (close_rec(mode_next, wbuf_next, wcount_next, to16(tstart_next)).rec_kind
                == REC_ERROR) begin
              cr.rec_kind = REC_ERROR;
            end
          end
          if (cr.rec_kind == REC_END) bnd = add_rec(bnd, cr);
        end
      end
      mode_next = MODE_IDLE;
      quote_single_next = 1'b0;
      esc_next = 1'b0;
      wcount_next = 16'd0;
      tstart_next = '0;
      offset_next = '0;
      err_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      quote_single <= 1'b0;
      esc <= 1'b0;
      wcount <= 16'd0;
      tstart <= '0;
      offset <= '0;
      err <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      quote_single <= quote_single_next;
      esc <= esc_next;
      wcount <= wcount_next;
      tstart <= tstart_next;
      offset <= offset_next;
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) wbuf <= wbuf_next;
  end

endmodule
`default_nettype wire

>>> design/fel_queue.sv
`default_nettype none
module fel_queue import fel_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output logic         q_valid,
  output bundle_t      q_data
);

  bundle_t    slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full = (fill == 2'(QUEUE_DEPTH));
  assign q_valid = (fill != 2'd0);
  assign q_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

>>> design/fel_back.sv
`default_nettype none
`include "filter_expression_lexer_macros.svh"
module fel_back import fel_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_valid,
  input  wire bundle_t q_data,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output rec_t         out_rec,
  output logic         out_last
);

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       load_out;
  logic       emit;
  logic       at_last;
  rec_t       sel;

  assign load_out = !out_valid || out_ready;
  assign emit = load_out && cur_valid;
  assign at_last = (3'(idx) == cur.count - 3'd1);
  assign pop = q_valid && (!cur_valid || (emit && at_last));
  assign sel = rec_t'(cur.recs[idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx <= 2'd0;
      end else if (emit && at_last) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx + 2'd1;
      end
      if (load_out) out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
    if (emit) begin
      out_rec <= sel;
      out_last <= at_last;
    end
  end

  `FEL_ASSERT(a_idx_in_bundle, !cur_valid || (3'(idx) < cur.count), "record index past bundle")
  `FEL_ASSERT(a_bundle_count, !cur_valid || cur.count - 3'd1 < 3'(MAX_RECORDS), "bad count")
  `FEL_ASSERT_NEXT(a_pop_loads, pop, cur_valid && idx == 2'd0, "popped bundle not loaded")

endmodule
`default_nettype wire

>>> design/filter_expression_lexer.sv
// Channel | Signals                                   | Beat
// input   | in_valid, in_ready, byte_valid, text_byte,  | one text byte or end mark
//         | end_of_text                               |
// output  | out_valid, out_ready, record_kind ... last_of_run | one lexer record
//
// An input beat is taken every cycle while the two-entry bundle queue has room.
// Results leave at one record per cycle while out_ready holds high; an item makes
// zero to four records, and the output register sets that rate.
// Reset returns the lexer to idle between tokens with offset zero.
// A stalled output fills the queue and then holds in_ready low.
`default_nettype none
module filter_expression_lexer import fel_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        byte_valid,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       record_kind,
  output logic [2:0]       token_kind,
  output logic [7:0]       value_char,
  output logic [15:0]      token_position,
  output logic [15:0]      token_length,
  output logic [4:0]       word_index,
  output logic [1:0]       error_code,
  output logic             last_of_run
);

  logic    push;
  bundle_t push_data;
  logic    queue_full;
  logic    pop;
  logic    q_valid;
  bundle_t q_data;
  rec_t    out_rec;

  fel_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .byte_valid(byte_valid), .text_byte(text_byte), .end_of_text(end_of_text),
    .push(push), .push_data(push_data), .queue_full(queue_full)
  );

  fel_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(queue_full),
    .pop(pop), .q_valid(q_valid), .q_data(q_data)
  );

  fel_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_rec(out_rec),
    .out_last(last_of_run)
  );

  assign record_kind = out_rec.rec_kind;
  assign token_kind = out_rec.tok_kind;
  assign value_char = out_rec.vchar;
  assign token_position = out_rec.pos;
  assign token_length = out_rec.len;
  assign word_index = out_rec.widx;
  assign error_code = out_rec.ecode;

endmodule
`default_nettype wire

>>> bench/tb_filter_expression_lexer.sv
`timescale 1ns / 100ps
module tb_filter_expression_lexer;
  import fel_pkg::*;

  typedef struct {
    logic       bv;
    logic [7:0] c;
    logic       eot;
    bit         drain;
  } text_item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  tok;
    logic [7:0]  ch;
    logic [15:0] pos;
    logic [15:0] len;
    logic [4:0]  widx;
    logic [1:0]  ecode;
    logic        last;
  } lex_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        byte_valid = 1'b0;
  logic [7:0]  text_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  record_kind;
  logic [2:0]  token_kind;
  logic [7:0]  value_char;
  logic [15:0] token_position;
  logic [15:0] token_length;
  logic [4:0]  word_index;
  logic [1:0]  error_code;
  logic        last_of_run;

  filter_expression_lexer u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .byte_valid(byte_valid), .text_byte(text_byte), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_ready(out_ready), .record_kind(record_kind),
    .token_kind(token_kind), .value_char(value_char),
    .token_position(token_position), .token_length(token_length),
    .word_index(word_index), .error_code(error_code), .last_of_run(last_of_run)
  );

  always #6 clk = ~clk;

  text_item_t pending_items[$];
  lex_rec_t   lex_expect[$];
  lex_rec_t   step_recs[$];
  int         fail_count = 0;
  int         rx_beats = 0;

  string op_words[19] = '{"!", "*", "**", "/", "+", "-", "%", "&", "|", "^",
                          "<", ">", ">=", "<=", "==", "!=", "=", "===", "!=="};
  string kw_words[5] = '{"in", "like", "true", "false", "null"};

  lex_mode_t   mode;
  bit          q_single;
  bit          esc;
  logic [7:0]  wbuf[5];
  int          wcnt;
  logic [15:0] tstart;
  logic [15:0] boff;
  bit          errl;

  function automatic bit ch_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit ch_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ch_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit ch_punct(logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic bit word_is(string w);
    if (wcnt != w.len()) return 0;
    for (int i = 0; i < w.len(); i++) begin
      if (wbuf[i] != w[i]) return 0;
    end
    return 1;
  endfunction

  task automatic clear_lexer();
    mode = MODE_IDLE;
    q_single = 0;
    esc = 0;
    wcnt = 0;
    tstart = '0;
    boff = '0;
    errl = 0;
  endtask

  task automatic emit_rec(rec_kind_t k, logic [2:0] t, logic [7:0] c, logic [15:0] p,
                          logic [15:0] l, logic [4:0] w, logic [1:0] e);
    lex_rec_t r;
    r = '{k, t, c, p, l, w, e, 1'b0};
    if (step_recs.size() < 4) step_recs = {step_recs, r};
  endtask

  task automatic append_char(logic [7:0] c);
    if (wcnt < 5) wbuf[wcnt] = c;
    if (wcnt < 65535) wcnt++;
  endtask

  task automatic raise_error(logic [1:0] code, logic [15:0] p);
    emit_rec(REC_ERROR, TOK_COMMA, 8'd0, p, 16'd0, 5'd0, code);
    errl = 1;
    mode = MODE_IDLE;
  endtask

  task automatic close_run(output bit ok);
    logic [2:0] kind;
    logic [4:0] idx;
    bit found;
    kind = TOK_IDENT;
    idx = 0;
    found = 0;
    if (mode == MODE_OPER) begin
      for (int i = 0; i < 19 && !found; i++) begin
        if (word_is(op_words[i])) begin
          found = 1;
          idx = 5'(i);
        end
      end
      if (!found) begin
        raise_error(ERR_BAD_OPER, tstart);
        ok = 0;
        return;
      end
      kind = TOK_OPER;
    end else if (mode == MODE_NUMBER) begin
      kind = TOK_NUMBER;
    end else begin
      for (int i = 0; i < 5 && !found; i++) begin
        if (word_is(kw_words[i])) begin
          found = 1;
          kind = TOK_KEYWORD;
          idx = 5'(i);
        end
      end
    end
    emit_rec(REC_CLOSED, kind, 8'd0, tstart, 16'(wcnt), idx, 2'd0);
    mode = MODE_IDLE;
    ok = 1;
  endtask

  task automatic start_token(logic [7:0] c, logic [15:0] at);
    logic [2:0] kind;
    if (ch_space(c)) return;
    if (c == "," || c == "(" || c == ")") begin
      kind = (c == ",") ? TOK_COMMA : TOK_PAREN;
      emit_rec(REC_VALUE, kind, c, at, 16'd0, 5'd0, 2'd0);
      emit_rec(REC_CLOSED, kind, 8'd0, at, 16'd1, 5'd0, 2'd0);
      return;
    end
    tstart = at;
    wcnt = 0;
    esc = 0;
    if (c == "\"" || c == "'") begin
      mode = MODE_STRING;
      q_single = (c == "'");
      return;
    end
    if (ch_punct(c)) begin
      mode = MODE_OPER;
      kind = TOK_OPER;
    end else if (ch_digit(c)) begin
      mode = MODE_NUMBER;
      kind = TOK_NUMBER;
    end else if (ch_alpha(c)) begin
      mode = MODE_IDENT;
      kind = TOK_IDENT;
    end else begin
      raise_error(ERR_BAD_CHAR, at);
      return;
    end
    append_char(c);
    emit_rec(REC_VALUE, kind, c, at, 16'd0, 5'd0, 2'd0);
  endtask

  task automatic take_char(logic [7:0] c, logic [15:0] at);
    logic [7:0] d;
    bit more;
    bit ok;
    if (mode == MODE_STRING) begin
      if (esc) begin
        d = (c == "n") ? 8'd10 : (c == "r") ? 8'd13 : (c == "t") ? 8'd9 : c;
        esc = 0;
        append_char(d);
        emit_rec(REC_VALUE, TOK_STRING, d, tstart, 16'd0, 5'd0, 2'd0);
      end else if (c == (q_single ? 8'h27 : 8'h22)) begin
        emit_rec(REC_CLOSED, TOK_STRING, 8'd0, tstart, 16'(wcnt), 5'd0, 2'd0);
        mode = MODE_IDLE;
      end else if (c == "\\") begin
        esc = 1;
      end else begin
        append_char(c);
        emit_rec(REC_VALUE, TOK_STRING, c, tstart, 16'd0, 5'd0, 2'd0);
      end
      return;
    end
    if (mode != MODE_IDLE) begin
      if (mode == MODE_OPER) more = ch_punct(c);
      else if (mode == MODE_NUMBER) more = ch_digit(c) || c == ".";
      else more = ch_alpha(c) || ch_digit(c) || c == "_";
      if (more) begin
        append_char(c);
        emit_rec(REC_VALUE, (mode == MODE_OPER) ? TOK_OPER :
                 (mode == MODE_NUMBER) ? TOK_NUMBER : TOK_IDENT,
                 c, tstart, 16'd0, 5'd0, 2'd0);
        return;
      end
      close_run(ok);
      if (!ok) return;
    end
    start_token(c, at);
  endtask

  task automatic lex_item(logic bv, logic [7:0] c, logic eot);
    logic [15:0] at;
    bit ok;
    step_recs.delete();
    if (bv) begin
      at = boff;
      if (boff != 16'hFFFF) boff++;
      if (!errl) take_char(c, at);
    end
    if (eot) begin
      if (!errl) begin
        if (mode == MODE_STRING) begin
          raise_error(ERR_UNCLOSED, tstart);
        end else begin
          ok = 1;
          if (mode != MODE_IDLE) close_run(ok);
          if (ok) emit_rec(REC_END, TOK_COMMA, 8'd0, boff, 16'd0, 5'd0, 2'd0);
        end
      end
      clear_lexer();
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
    foreach (step_recs[i]) lex_expect = {lex_expect, step_recs[i]};
  endtask

  int tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        lex_item(byte_valid, text_byte, end_of_text);
        tx_gap = $urandom_range(0, 3);
      end
      if (!(in_valid && !in_ready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && (lex_expect.size() > 0 || in_valid))) begin
          byte_valid <= pending_items[0].bv;
          text_byte <= pending_items[0].c;
          end_of_text <= pending_items[0].eot;
          in_valid <= 1'b1;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int rx_gap = 0;
  int rx_hold = 0;

  task automatic check_rec(lex_rec_t e);
    if (record_kind !== e.kind)
      $error("record_kind expected %0d actual %0d", e.kind, record_kind);
    if (token_kind !== e.tok)
      $error("token_kind expected %0d actual %0d", e.tok, token_kind);
    if (value_char !== e.ch)
      $error("value_char expected %0d actual %0d", e.ch, value_char);
    if (token_position !== e.pos)
      $error("token_position expected %0d actual %0d", e.pos, token_position);
    if (token_length !== e.len)
      $error("token_length expected %0d actual %0d", e.len, token_length);
    if (word_index !== e.widx)
      $error("word_index expected %0d actual %0d", e.widx, word_index);
    if (error_code !== e.ecode)
      $error("error_code expected %0d actual %0d", e.ecode, error_code);
    if (last_of_run !== e.last)
      $error("last_of_run expected %0d actual %0d", e.last, last_of_run);
    if (record_kind !== e.kind || token_kind !== e.tok || value_char !== e.ch ||
        token_position !== e.pos || token_length !== e.len || word_index !== e.widx ||
        error_code !== e.ecode || last_of_run !== e.last)
      fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (lex_expect.size() == 0) begin
          $error("unexpected record, kind %0d", record_kind);
          fail_count++;
        end else begin
          check_rec(lex_expect.pop_front());
        end
        rx_beats++;
        rx_gap = $urandom_range(0, 3);
        if (rx_beats == 150) rx_hold = 300;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic put_item(logic bv, logic [7:0] c, logic eot);
    text_item_t it;
    it = '{bv, c, eot, 0};
    pending_items = {pending_items, it};
  endtask

  task automatic put_text(string s, bit with_end);
    for (int i = 0; i < s.len(); i++) put_item(1'b1, s[i], with_end && i == s.len() - 1);
  endtask

  function automatic string rand_token();
    string s;
    string esc_set;
    int n;
    s = "";
    esc_set = "nrt\\'\"x";
    case ($urandom_range(0, 6))
      0: s = ($urandom_range(0, 1)) ? "," : (($urandom_range(0, 1)) ? "(" : ")");
      1: s = op_words[$urandom_range(0, 18)];
      2: s = kw_words[$urandom_range(0, 4)];
      3: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          s = {s, string'(($urandom_range(0, 3) == 0) ? 8'("0") + 8'($urandom_range(0, 9)) :
                          8'("a") + 8'($urandom_range(0, 25)))};
        if ($urandom_range(0, 3) == 0) s = {s, "_Z9"};
      end
      4: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          s = {s, string'(($urandom_range(0, 4) == 0) ? 8'(".") :
                          8'("0") + 8'($urandom_range(0, 9)))};
      end
      default: begin
        n = $urandom_range(0, 4);
        s = ($urandom_range(0, 1)) ? "'" : "\"";
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 4))
            0: s = {s, "\\", string'(esc_set[$urandom_range(0, 6)])};
            default: s = {s, string'(8'($urandom_range(32, 126) & 8'h7F) == 8'h5C ?
                                     8'h41 : 8'($urandom_range(32, 126)))};
          endcase
        end
        s = {s, string'(s[0])};
      end
    endcase
    return s;
  endfunction

  initial begin
    int sent;
    string expr;
    text_item_t it;
    bit drained;
    clear_lexer();
    drained = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    put_text("x=== 'a\\n'(1.5,in)", 0);
    put_item(1'b0, 8'hA5, 1'b1);
    put_text("@", 0);
    put_text("b", 1);
    put_text("\"ab\\", 1);
    put_text(" #~ ", 1);
    put_item(1'b1, 8'h80, 1'b0);
    put_item(1'b1, 8'hFF, 1'b1);
    put_text("._ ", 1);

    sent = pending_items.size();
    while (sent < 430) begin
      if ($urandom_range(0, 9) == 0) begin
        put_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        expr = "";
        for (int t = $urandom_range(1, 7); t > 0; t--) begin
          expr = {expr, rand_token()};
          if ($urandom_range(0, 4) != 0) expr = {expr, " "};
        end
        if ($urandom_range(0, 7) == 0) expr = {expr, string'(8'($urandom_range(0, 255)))};
        if ($urandom_range(0, 1)) begin
          put_text(expr, 1);
        end else begin
          put_text(expr, 0);
          put_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
          sent++;
        end
        sent += expr.len();
      end
      if (!drained && sent > 200 && pending_items.size() > 0) begin
        it = pending_items[pending_items.size() - 1];
        it.drain = 1;
        pending_items[pending_items.size() - 1] = it;
        drained = 1;
      end
    end

    while (pending_items.size() > 0 || in_valid || lex_expect.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/fel_pkg.sv
design/fel_front.sv
design/fel_queue.sv
design/fel_back.sv
design/filter_expression_lexer.sv
bench/tb_filter_expression_lexer.sv
